FILE: rtl/gld_pkg.sv
// shared types and constants of the gif lzw decoder
`timescale 1ns / 1ps
package gld_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
  localparam int STACK_DEPTH   = 8192;
  localparam int ACC_BITS      = 24;
  localparam int TIDX_W        = MAX_CODE_BITS;
  localparam int CODE_W        = MAX_CODE_BITS + 1;
  localparam int LIMIT_W       = MAX_CODE_BITS + 2;
  localparam int SIDX_W        = $clog2(STACK_DEPTH);
  localparam int SCNT_W        = SIDX_W + 1;
  localparam int FILL_W        = $clog2(ACC_BITS + 1);
  localparam int WID_W         = 4;
  localparam int BYTE_W        = 8;
  localparam int MIN_SIZE      = 2;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_FEED    = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_REFUSED = 3'd2,
    ST_NEED    = 3'd3,
    ST_END     = 3'd4,
    ST_ERROR   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FIRST = 3'd1,
    PH_RUN   = 3'd2,
    PH_ENDED = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_FAIL,
    CMD_FEED,
    CMD_POP,
    CMD_TAKE,
    CMD_CLEAR,
    CMD_FIRST,
    CMD_END,
    CMD_BEGIN,
    CMD_READ,
    CMD_STEP,
    CMD_ROOT
  } cmd_e;

  typedef struct packed {
    phase_e              phase;
    logic                stack_empty;
    logic                need_bits;
    logic                stream_done;
    logic                code_clear;
    logic                code_gt_clear;
    logic                code_stop;
    logic                walk_more;
    logic                circular;
    status_e             feed_st;
    logic [BYTE_W-1:0]   stk_pix;
    logic [BYTE_W-1:0]   code_pix;
  } dp_stat_t;

endpackage

FILE: rtl/gld_in_if.sv
// input channel: action and data byte
`timescale 1ns / 1ps
interface gld_in_if;
  import gld_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

FILE: rtl/gld_out_if.sv
// output channel: status and pixel
`timescale 1ns / 1ps
interface gld_out_if;
  import gld_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [BYTE_W-1:0] pixel;
  modport source (output valid, status, pixel, input ready);
  modport sink (input valid, status, pixel, output ready);
endinterface

FILE: rtl/gld_datapath.sv
// decoder datapath: bit accumulator, string tables, string stack
`timescale 1ns / 1ps
module gld_datapath import gld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  input  logic [BYTE_W-1:0] data_i,
  output dp_stat_t          stat_o
);

  logic [TIDX_W-1:0]  prefix_mem [TABLE_SIZE];
  logic [BYTE_W-1:0]  suffix_mem [TABLE_SIZE];
  logic [BYTE_W-1:0]  stack_mem  [STACK_DEPTH];

  phase_e             phase_q;
  logic [ACC_BITS-1:0] acc_q;
  logic [FILL_W-1:0]  fill_q;
  logic [BYTE_W-1:0]  blk_q;
  logic               done_q;
  logic [WID_W-1:0]   base_q;
  logic [WID_W-1:0]   width_q;
  logic [CODE_W-1:0]  nf_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [BYTE_W-1:0]  fc_q;
  logic [CODE_W-1:0]  prev_q;
  logic [SCNT_W-1:0]  cnt_q;
  logic [CODE_W-1:0]  code_q;
  logic [CODE_W-1:0]  cur_q;
  logic [CODE_W-1:0]  incode_q;
  logic [TIDX_W-1:0]  pre_rd_q;
  logic [BYTE_W-1:0]  suf_rd_q;
  logic               tab_ok_q;
  logic [BYTE_W-1:0]  suf_dflt_q;
  logic [BYTE_W-1:0]  stk_rd_q;

  logic [CODE_W-1:0]  clear_w;
  logic [CODE_W-1:0]  mask_w;
  logic [CODE_W-1:0]  code_w;
  logic               full_w;
  logic [CODE_W-1:0]  pre_val_w;
  logic [BYTE_W-1:0]  suf_val_w;
  logic               push_w;
  logic [BYTE_W-1:0]  push_val_w;
  logic [BYTE_W-1:0]  fc_new_w;
  logic               add_w;
  logic [CODE_W-1:0]  nf_inc_w;
  logic [TIDX_W-1:0]  cur_idx_w;
  status_e            feed_st_w;

  assign clear_w   = CODE_W'(1) << base_q;
  assign mask_w    = CODE_W'((LIMIT_W'(1) << width_q) - LIMIT_W'(1));
  assign code_w    = acc_q[CODE_W-1:0] & mask_w;
  assign full_w    = cnt_q[SCNT_W-1];
  assign cur_idx_w = cur_q[TIDX_W-1:0];
  assign pre_val_w = tab_ok_q ? {1'b0, pre_rd_q} : '0;
  assign suf_val_w = tab_ok_q ? suf_rd_q : suf_dflt_q;
  assign fc_new_w  = full_w ? fc_q : cur_q[BYTE_W-1:0];
  assign add_w     = (cmd_i == CMD_ROOT) && (nf_q < CODE_W'(TABLE_SIZE));
  assign nf_inc_w  = nf_q + CODE_W'(1);

  always_comb begin
    feed_st_w = ST_REFUSED;
    if (phase_q == PH_IDLE || phase_q == PH_ERROR || done_q) begin
      feed_st_w = ST_REFUSED;
    end else if (blk_q == '0 || phase_q == PH_ENDED) begin
      feed_st_w = ST_TAKEN;
    end else if (fill_q <= FILL_W'(ACC_BITS - BYTE_W)) begin
      feed_st_w = ST_TAKEN;
    end
  end

  // single stack write port
  always_comb begin
    push_w     = 1'b0;
    push_val_w = fc_q;
    case (cmd_i)
      CMD_BEGIN: begin
        push_w     = (code_q == nf_q);
        push_val_w = fc_q;
      end
      CMD_STEP: begin
        push_w     = 1'b1;
        push_val_w = suf_val_w;
      end
      CMD_ROOT: begin
        push_w     = 1'b1;
        push_val_w = cur_q[BYTE_W-1:0];
      end
      default: push_w = 1'b0;
    endcase
    push_w = push_w && !full_w;
  end

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      stack_mem[cnt_q[SIDX_W-1:0]] <= push_val_w;
    end
    if (cmd_i == CMD_POP) begin
      stk_rd_q <= stack_mem[SIDX_W'(cnt_q - SCNT_W'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_w) begin
      prefix_mem[nf_q[TIDX_W-1:0]] <= prev_q[TIDX_W-1:0];
      suffix_mem[nf_q[TIDX_W-1:0]] <= fc_new_w;
    end
    if (cmd_i == CMD_READ) begin
      pre_rd_q   <= prefix_mem[cur_idx_w];
      suf_rd_q   <= suffix_mem[cur_idx_w];
      // entries outside the filled range read prefix zero and, for root codes, their own index as suffix
      tab_ok_q   <= ({1'b0, cur_idx_w} >= clear_w + CODE_W'(2)) &&
                    ({1'b0, cur_idx_w} < nf_q);
      suf_dflt_q <= ({1'b0, cur_idx_w} < clear_w) ? cur_idx_w[BYTE_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      fill_q   <= '0;
      blk_q    <= '0;
      done_q   <= 1'b0;
      base_q   <= '0;
      width_q  <= '0;
      nf_q     <= '0;
      limit_q  <= '0;
      fc_q     <= '0;
      prev_q   <= '0;
      cnt_q    <= '0;
      code_q   <= '0;
      cur_q    <= '0;
      incode_q <= '0;
    end else begin
      if (push_w) begin
        cnt_q <= cnt_q + SCNT_W'(1);
      end
      case (cmd_i)
        CMD_START: begin
          base_q  <= data_i[WID_W-1:0];
          width_q <= data_i[WID_W-1:0] + WID_W'(1);
          limit_q <= LIMIT_W'(2) << data_i[WID_W-1:0];
          nf_q    <= (CODE_W'(1) << data_i[WID_W-1:0]) + CODE_W'(2);
          cnt_q   <= '0;
          acc_q   <= '0;
          fill_q  <= '0;
          blk_q   <= '0;
          done_q  <= 1'b0;
          fc_q    <= '0;
          prev_q  <= '0;
          phase_q <= PH_FIRST;
        end
        CMD_FAIL: phase_q <= PH_ERROR;
        CMD_FEED: begin
          if (feed_st_w == ST_TAKEN) begin
            if (blk_q == '0) begin
              if (data_i == '0) begin
                done_q <= 1'b1;
              end else begin
                blk_q <= data_i;
              end
            end else begin
              blk_q <= blk_q - BYTE_W'(1);
              if (phase_q != PH_ENDED) begin
                acc_q  <= acc_q | (ACC_BITS'(data_i) << fill_q);
                fill_q <= fill_q + FILL_W'(BYTE_W);
              end
            end
          end
        end
        CMD_POP: cnt_q <= cnt_q - SCNT_W'(1);
        CMD_TAKE: begin
          code_q <= code_w;
          acc_q  <= acc_q >> width_q;
          fill_q <= fill_q - FILL_W'(width_q);
        end
        CMD_CLEAR: begin
          width_q <= base_q + WID_W'(1);
          limit_q <= LIMIT_W'(2) << base_q;
          nf_q    <= clear_w + CODE_W'(2);
          cnt_q   <= '0;
          phase_q <= PH_FIRST;
        end
        CMD_FIRST: begin
          fc_q    <= code_q[BYTE_W-1:0];
          prev_q  <= code_q;
          phase_q <= PH_RUN;
        end
        CMD_END: phase_q <= PH_ENDED;
        CMD_BEGIN: begin
          incode_q <= code_q;
          cur_q    <= (code_q == nf_q) ? prev_q : code_q;
        end
        CMD_STEP: cur_q <= pre_val_w;
        CMD_ROOT: begin
          fc_q   <= fc_new_w;
          prev_q <= incode_q;
          if (add_w) begin
            nf_q <= nf_inc_w;
            if ({1'b0, nf_inc_w} >= limit_q && limit_q < LIMIT_W'(TABLE_SIZE)) begin
              limit_q <= limit_q << 1;
              width_q <= width_q + WID_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.phase         = phase_q;
  assign stat_o.stack_empty   = (cnt_q == '0);
  assign stat_o.need_bits     = fill_q < FILL_W'(width_q);
  assign stat_o.stream_done   = done_q;
  assign stat_o.code_clear    = (code_q == clear_w);
  assign stat_o.code_gt_clear = (code_q > clear_w);
  assign stat_o.code_stop     = (code_q == clear_w + CODE_W'(1)) || (code_q > nf_q);
  assign stat_o.walk_more     = (cur_q >= clear_w) && !full_w;
  assign stat_o.circular      = (pre_val_w == cur_q);
  assign stat_o.feed_st       = feed_st_w;
  assign stat_o.stk_pix       = stk_rd_q;
  assign stat_o.code_pix      = code_q[BYTE_W-1:0];

endmodule

FILE: rtl/gld_controller.sv
// decoder controller: sequences each word and holds the result register
`timescale 1ns / 1ps
module gld_controller import gld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [BYTE_W-1:0] data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [BYTE_W-1:0] pixel_o,
  output cmd_e              cmd_o,
  input  dp_stat_t          stat_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_REQ, S_POP, S_CODE, S_WALK, S_STEP
  } state_e;

  state_e            state_q, state_d;
  logic              vld_q;
  status_e           st_q, st_d;
  logic [BYTE_W-1:0] pix_q, pix_d;
  logic              load_d;
  logic              accept_w;

  assign in_ready_o = (state_q == S_IDLE) && (!vld_q || out_ready_i);
  assign accept_w   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    load_d  = 1'b0;
    st_d    = ST_REFUSED;
    pix_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          case (action_i)
            ACT_START: begin
              load_d = 1'b1;
              if (data_i < BYTE_W'(MIN_SIZE) || data_i > BYTE_W'(MAX_CODE_BITS)) begin
                cmd_o = CMD_FAIL;
                st_d  = ST_ERROR;
              end else begin
                cmd_o = CMD_START;
                st_d  = ST_TAKEN;
              end
            end
            ACT_FEED: begin
              load_d = 1'b1;
              cmd_o  = CMD_FEED;
              st_d   = stat_i.feed_st;
            end
            ACT_REQUEST: state_d = S_REQ;
            default: begin
              load_d = 1'b1;
              st_d   = ST_REFUSED;
            end
          endcase
        end
      end
      S_REQ: begin
        if (stat_i.phase == PH_IDLE || stat_i.phase == PH_ERROR) begin
          load_d = 1'b1;
          st_d   = ST_ERROR;
        end else if (stat_i.phase == PH_ENDED) begin
          load_d = 1'b1;
          st_d   = ST_END;
        end else if (!stat_i.stack_empty) begin
          cmd_o   = CMD_POP;
          state_d = S_POP;
        end else if (stat_i.need_bits) begin
          load_d = 1'b1;
          if (stat_i.stream_done) begin
            cmd_o = CMD_FAIL;
            st_d  = ST_ERROR;
          end else begin
            st_d = ST_NEED;
          end
        end else begin
          cmd_o   = CMD_TAKE;
          state_d = S_CODE;
        end
      end
      S_POP: begin
        load_d = 1'b1;
        st_d   = ST_PIXEL;
        pix_d  = stat_i.stk_pix;
      end
      S_CODE: begin
        if (stat_i.code_clear) begin
          cmd_o   = CMD_CLEAR;
          state_d = S_REQ;
        end else if (stat_i.phase == PH_FIRST) begin
          load_d = 1'b1;
          if (stat_i.code_gt_clear) begin
            cmd_o = CMD_END;
            st_d  = ST_END;
          end else begin
            cmd_o = CMD_FIRST;
            st_d  = ST_PIXEL;
            pix_d = stat_i.code_pix;
          end
        end else if (stat_i.code_stop) begin
          load_d = 1'b1;
          cmd_o  = CMD_END;
          st_d   = ST_END;
        end else begin
          cmd_o   = CMD_BEGIN;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_more) begin
          cmd_o   = CMD_READ;
          state_d = S_STEP;
        end else begin
          cmd_o   = CMD_ROOT;
          state_d = S_REQ;
        end
      end
      S_STEP: begin
        if (stat_i.circular) begin
          load_d = 1'b1;
          cmd_o  = CMD_FAIL;
          st_d   = ST_ERROR;
        end else begin
          cmd_o   = CMD_STEP;
          state_d = S_WALK;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (load_d) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
      st_q    <= ST_PIXEL;
      pix_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_d) begin
        vld_q <= 1'b1;
        st_q  <= st_d;
        pix_q <= pix_d;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = vld_q;
  assign status_o    = st_q;
  assign pixel_o     = pix_q;

endmodule

FILE: rtl/gif_lzw_decoder_top.sv
// top level of the pull-model gif lzw decoder
`timescale 1ns / 1ps
// usage
//   in_i carries one word per operation: action (start, feed byte, request
//   pixel) and data_byte; out_o returns exactly one status word per input
//   word, with the pixel index when the status is pixel
//   a word is taken on a rising edge with valid and ready both high
// sequence
//   start, feed and unused actions answer in the cycle after acceptance
//   a request served from the string stack passes S_REQ and S_POP; a
//   request that has to decode a code fetches it in S_REQ and S_CODE,
//   walks each table entry through the prefix/suffix memories (one read
//   port) in S_WALK and S_STEP, handles the root in S_WALK, then answers as a
//   stack request does; one word is in flight at a time
//   a clear code returns to S_REQ for the next code, no table sweep is needed
// reset
//   asynchronous, active low; the decoder comes up not started and needs a
//   start word; table contents are never cleared, the fill count guards them
// stalls
//   a waiting result sits in the output register; the next word is taken
//   in the cycle the result is taken or once it has gone
module gif_lzw_decoder_top import gld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gld_in_if.sink    in_i,
  gld_out_if.source out_o
);

  cmd_e     cmd;
  dp_stat_t stat;

  // sequencer and result register
  gld_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .action_i    (in_i.action),
    .data_i      (in_i.data_byte),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_o    (out_o.status),
    .pixel_o     (out_o.pixel),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // decoder state, tables and stack
  gld_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .data_i (in_i.data_byte),
    .stat_o (stat)
  );

endmodule

FILE: rtl/gld_checker.sv
// port-level checks of the decoder
`timescale 1ns / 1ps
module gld_checker import gld_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        status_i,
  input logic [BYTE_W-1:0] pixel_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(pixel_i))
    else $error("stalled result changed");

  // only pixel results carry a pixel
  a_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_PIXEL |-> pixel_i == '0)
    else $error("pixel set on non-pixel status");

  // status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_ERROR)
    else $error("bad status code");

  // a word is only taken when the result register is free or emptying
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("word taken over a waiting result");

endmodule

bind gif_lzw_decoder_top gld_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .pixel_i     (out_o.pixel)
);
